>>> hw/rtl/assert_macros.svh
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, disabled while reset is low
`define ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_NOW(lbl, clk, rstn, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

>>> hw/rtl/dnsx_pkg.sv
package dnsx_pkg;

    // parser phases
    localparam logic [3:0] PH_HEADER = 4'd0;
    localparam logic [3:0] PH_NAME   = 4'd1;
    localparam logic [3:0] PH_LABEL  = 4'd2;
    localparam logic [3:0] PH_PTR    = 4'd3;
    localparam logic [3:0] PH_QFIX   = 4'd4;
    localparam logic [3:0] PH_AFIX   = 4'd5;
    localparam logic [3:0] PH_ADATA  = 4'd6;
    localparam logic [3:0] PH_ASKIP  = 4'd7;
    localparam logic [3:0] PH_DONE   = 4'd8;

    // result status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_SHORT     = 3'd1;
    localparam logic [2:0] ST_ID        = 3'd2;
    localparam logic [2:0] ST_RCODE     = 3'd3;
    localparam logic [2:0] ST_NO_ANS    = 3'd4;
    localparam logic [2:0] ST_BAD_LABEL = 3'd5;
    localparam logic [2:0] ST_TRUNC     = 3'd6;
    localparam logic [2:0] ST_NO_A      = 3'd7;

    // byte positions and record constants
    localparam logic [3:0]  HDR_ID_HI   = 4'd0;
    localparam logic [3:0]  HDR_ID_LO   = 4'd1;
    localparam logic [3:0]  HDR_FLAGS   = 4'd3;
    localparam logic [3:0]  HDR_QD_HI   = 4'd4;
    localparam logic [3:0]  HDR_QD_LO   = 4'd5;
    localparam logic [3:0]  HDR_AN_HI   = 4'd6;
    localparam logic [3:0]  HDR_AN_LO   = 4'd7;
    localparam logic [3:0]  HDR_LAST    = 4'd11;
    localparam logic [3:0]  AF_TYPE_HI  = 4'd0;
    localparam logic [3:0]  AF_TYPE_LO  = 4'd1;
    localparam logic [3:0]  AF_LEN_HI   = 4'd8;
    localparam logic [3:0]  AF_LEN_LO   = 4'd9;
    localparam logic [15:0] QFIX_LEN    = 16'd4;
    localparam logic [15:0] TYPE_A      = 16'd1;
    localparam logic [15:0] ADDR_LEN    = 16'd4;
    localparam logic [1:0]  LBL_PTR     = 2'b11;
    localparam logic [1:0]  LBL_PLAIN   = 2'b00;

    typedef struct packed {
        logic        found;
        logic [31:0] address;
        logic [2:0]  status;
    } t_result;

endpackage

>>> hw/rtl/dnsx_parse.sv
module dnsx_parse
    import dnsx_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_take,
    input  logic [7:0]  i_byte,
    input  logic        i_last,
    input  logic [15:0] i_expected_id,
    output t_result     o_result
);

    logic [3:0]  r_phase,   n_phase;
    logic [3:0]  r_cnt,     n_cnt;
    logic [15:0] r_qd,      n_qd;
    logic [15:0] r_an,      n_an;
    logic [15:0] r_skip,    n_skip;
    logic [15:0] r_type,    n_type;
    logic [7:0]  r_len_hi,  n_len_hi;
    logic [31:0] r_addr,    n_addr;
    logic [2:0]  r_outcome, n_outcome;

    logic [15:0] skip_dec;
    logic [15:0] an_dec;
    logic [15:0] rec_len;
    logic [2:0]  hdr_outcome;
    logic [2:0]  code;

    assign skip_dec = r_skip - 16'd1;
    assign an_dec   = r_an - 16'd1;
    assign rec_len  = {r_len_hi, i_byte};

    always_comb begin
        n_phase     = r_phase;
        n_cnt       = r_cnt;
        n_qd        = r_qd;
        n_an        = r_an;
        n_skip      = r_skip;
        n_type      = r_type;
        n_len_hi    = r_len_hi;
        n_addr      = r_addr;
        n_outcome   = r_outcome;
        hdr_outcome = r_outcome;
        code        = ST_OK;
        o_result    = '0;
        if (i_take) begin
            unique case (r_phase)
                PH_HEADER: begin
                    if (r_cnt == HDR_ID_HI) begin
                        n_type = {i_byte, 8'h00};
                    end else if (r_cnt == HDR_ID_LO) begin
                        n_type = {r_type[15:8], i_byte};
                        if ({r_type[15:8], i_byte} != i_expected_id) begin
                            n_outcome = ST_ID;
                        end
                    end else if (r_cnt == HDR_FLAGS) begin
                        if (i_byte[3:0] != 4'd0 && r_outcome == ST_OK) begin
                            n_outcome = ST_RCODE;
                        end
                    end else if (r_cnt == HDR_QD_HI) begin
                        n_qd = {i_byte, 8'h00};
                    end else if (r_cnt == HDR_QD_LO) begin
                        n_qd = {r_qd[15:8], i_byte};
                    end else if (r_cnt == HDR_AN_HI) begin
                        n_an = {i_byte, 8'h00};
                    end else if (r_cnt == HDR_AN_LO) begin
                        n_an = {r_an[15:8], i_byte};
                    end
                    if (r_cnt == HDR_LAST) begin
                        if (r_outcome == ST_OK && r_an == 16'd0) begin
                            hdr_outcome = ST_NO_ANS;
                        end
                        n_outcome = hdr_outcome;
                        n_phase   = (hdr_outcome != ST_OK) ? PH_DONE : PH_NAME;
                    end else begin
                        n_cnt = r_cnt + 4'd1;
                    end
                end
                PH_NAME: begin
                    if (i_byte == 8'h00) begin
                        n_cnt = '0;
                        if (r_qd != 16'd0) begin
                            n_phase = PH_QFIX;
                            n_skip  = QFIX_LEN;
                        end else begin
                            n_phase = PH_AFIX;
                        end
                    end else if (i_byte[7:6] == LBL_PTR) begin
                        n_phase = PH_PTR;
                    end else if (i_byte[7:6] != LBL_PLAIN) begin
                        n_outcome = ST_BAD_LABEL;
                        n_phase   = PH_DONE;
                    end else begin
                        n_skip  = {8'h00, i_byte};
                        n_phase = PH_LABEL;
                    end
                end
                PH_LABEL: begin
                    n_skip = skip_dec;
                    if (skip_dec == 16'd0) begin
                        n_phase = PH_NAME;
                    end
                end
                PH_PTR: begin
                    n_cnt = '0;
                    if (r_qd != 16'd0) begin
                        n_phase = PH_QFIX;
                        n_skip  = QFIX_LEN;
                    end else begin
                        n_phase = PH_AFIX;
                    end
                end
                PH_QFIX: begin
                    n_skip = skip_dec;
                    if (skip_dec == 16'd0) begin
                        n_qd    = r_qd - 16'd1;
                        n_phase = PH_NAME;
                    end
                end
                PH_AFIX: begin
                    if (r_cnt == AF_TYPE_HI) begin
                        n_type = {i_byte, 8'h00};
                    end else if (r_cnt == AF_TYPE_LO) begin
                        n_type = {r_type[15:8], i_byte};
                    end else if (r_cnt == AF_LEN_HI) begin
                        n_len_hi = i_byte;
                    end
                    if (r_cnt == AF_LEN_LO) begin
                        n_cnt = '0;
                        if (r_type == TYPE_A && rec_len == ADDR_LEN) begin
                            n_skip  = ADDR_LEN;
                            n_addr  = '0;
                            n_phase = PH_ADATA;
                        end else if (rec_len != 16'd0) begin
                            n_skip  = rec_len;
                            n_phase = PH_ASKIP;
                        end else begin
                            n_an = an_dec;
                            if (an_dec == 16'd0) begin
                                n_outcome = ST_NO_A;
                                n_phase   = PH_DONE;
                            end else begin
                                n_phase = PH_NAME;
                            end
                        end
                    end else begin
                        n_cnt = r_cnt + 4'd1;
                    end
                end
                PH_ADATA: begin
                    n_addr = {r_addr[23:0], i_byte};
                    n_skip = skip_dec;
                    if (skip_dec == 16'd0) begin
                        n_outcome = ST_OK;
                        n_phase   = PH_DONE;
                    end
                end
                PH_ASKIP: begin
                    n_skip = skip_dec;
                    if (skip_dec == 16'd0) begin
                        n_an = an_dec;
                        if (an_dec == 16'd0) begin
                            n_outcome = ST_NO_A;
                            n_phase   = PH_DONE;
                        end else begin
                            n_phase = PH_NAME;
                        end
                    end
                end
                default: begin
                    // settled: bytes are ignored until the last one
                end
            endcase

            // report on the last byte, then start afresh
            if (i_last) begin
                if (n_phase == PH_DONE) begin
                    code = n_outcome;
                end else if (n_phase == PH_HEADER) begin
                    code = ST_SHORT;
                end else begin
                    code = ST_TRUNC;
                end
                o_result.status  = code;
                o_result.found   = (code == ST_OK);
                o_result.address = (code == ST_OK) ? n_addr : 32'd0;
                n_phase   = PH_HEADER;
                n_cnt     = '0;
                n_qd      = '0;
                n_an      = '0;
                n_skip    = '0;
                n_type    = '0;
                n_len_hi  = '0;
                n_addr    = '0;
                n_outcome = ST_OK;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HEADER;
            r_cnt     <= '0;
            r_qd      <= '0;
            r_an      <= '0;
            r_skip    <= '0;
            r_type    <= '0;
            r_len_hi  <= '0;
            r_addr    <= '0;
            r_outcome <= ST_OK;
        end else begin
            r_phase   <= n_phase;
            r_cnt     <= n_cnt;
            r_qd      <= n_qd;
            r_an      <= n_an;
            r_skip    <= n_skip;
            r_type    <= n_type;
            r_len_hi  <= n_len_hi;
            r_addr    <= n_addr;
            r_outcome <= n_outcome;
        end
    end

endmodule

>>> hw/rtl/dnsx_out_reg.sv
module dnsx_out_reg
    import dnsx_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_result,
    input  logic    i_ready,
    output logic    o_space,
    output logic    o_valid,
    output t_result o_result
);

    logic    r_valid, n_valid;
    t_result r_result;

    assign o_space  = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule

>>> hw/rtl/dns_a_record_extractor.sv
// dns response a-record extractor: takes a dns response one byte per word, last byte flagged,
// and gives one word per packet with a status and the first ipv4 address found in an answer
// of type 1 with data length 4. a byte is registered on entry and parsed from that register by
// a single state update; the result is loaded into an output register on the edge that parses
// the packet's last byte, so the result word is valid from that edge. one byte is taken every
// cycle; only a last byte waits, and only while the output register still holds an unaccepted
// result, so the next packet can start while a finished result waits. the user must write
// expected_id through i_cfg_we/i_cfg_data only while idle; the block does not enforce it.
`include "assert_macros.svh"

module dns_a_record_extractor
    import dnsx_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_found,
    output logic [31:0] o_address,
    output logic [2:0]  o_status
);

    logic [15:0] r_expected_id;
    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_last;

    logic        take;
    logic        out_space;
    t_result     parse_result;
    t_result     out_result;

    // a last byte only moves on when the result register can take its word
    assign take    = r_in_valid && (!r_in_last || out_space);
    assign o_ready = !r_in_valid || take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected_id <= '0;
            r_in_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_expected_id <= i_cfg_data;
            end
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in_byte <= i_data_byte;
            r_in_last <= i_last;
        end
    end

    dnsx_parse u_parse (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_take        (take),
        .i_byte        (r_in_byte),
        .i_last        (r_in_last),
        .i_expected_id (r_expected_id),
        .o_result      (parse_result)
    );

    dnsx_out_reg u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (take && r_in_last),
        .i_result (parse_result),
        .i_ready  (i_ready),
        .o_space  (out_space),
        .o_valid  (o_valid),
        .o_result (out_result)
    );

    assign o_found   = out_result.found;
    assign o_address = out_result.address;
    assign o_status  = out_result.status;

    `ASSERT_NOW(a_found_ok, i_clk, i_rst_n, o_valid, o_found == (o_status == ST_OK), "bad found")
    `ASSERT_NOW(a_addr_zero, i_clk, i_rst_n, o_valid && !o_found, o_address == 32'd0, "stray address")
    `ASSERT_NEXT(a_last_result, i_clk, i_rst_n, take && r_in_last, o_valid, "no result word")
    `ASSERT_NOW(a_no_overrun, i_clk, i_rst_n, take && r_in_last, out_space, "result overrun")

endmodule

>>> bench/dns_a_record_extractor_test.sv
module dns_a_record_extractor_test;
    import dnsx_pkg::*;

    // tracks the parse of the response stream and holds the result words still owed
    class dns_reply_tracker;
        logic [15:0] id_cfg;
        logic [3:0]  phase;
        logic [3:0]  pos;
        logic [15:0] id_seen;
        logic [15:0] qd_left;
        logic [15:0] an_left;
        logic [15:0] skip_left;
        logic [15:0] rr_type;
        logic [15:0] rr_len;
        logic [31:0] addr_acc;
        logic [2:0]  outcome;
        logic        settled;
        t_result     pending[$];
        int unsigned errors;

        function new();
            id_cfg = 16'h0000;
            errors = 0;
            clear();
        endfunction

        function void clear();
            phase     = PH_HEADER;
            pos       = 4'd0;
            id_seen   = 16'h0000;
            qd_left   = 16'h0000;
            an_left   = 16'h0000;
            skip_left = 16'h0000;
            rr_type   = 16'h0000;
            rr_len    = 16'h0000;
            addr_acc  = 32'h0;
            outcome   = ST_OK;
            settled   = 1'b0;
        endfunction

        function void settle(input logic [2:0] code);
            outcome = code;
            settled = 1'b1;
            phase   = PH_DONE;
        endfunction

        function void name_done();
            pos = 4'd0;
            if (qd_left != 16'h0000) begin
                phase     = PH_QFIX;
                skip_left = QFIX_LEN;
            end else begin
                phase = PH_AFIX;
            end
        endfunction

        function void answer_done();
            an_left = an_left - 16'd1;
            if (an_left == 16'h0000)
                settle(ST_NO_A);
            else
                phase = PH_NAME;
        endfunction

        function void parse_byte(input logic [7:0] b);
            case (phase)
                PH_HEADER: begin
                    case (pos)
                        HDR_ID_HI: id_seen[15:8] = b;
                        HDR_ID_LO: begin
                            id_seen[7:0] = b;
                            if (id_seen != id_cfg)
                                outcome = ST_ID;
                        end
                        HDR_FLAGS: begin
                            if (b[3:0] != 4'h0 && outcome == ST_OK)
                                outcome = ST_RCODE;
                        end
                        HDR_QD_HI: qd_left[15:8] = b;
                        HDR_QD_LO: qd_left[7:0] = b;
                        HDR_AN_HI: an_left[15:8] = b;
                        HDR_AN_LO: an_left[7:0] = b;
                        default: ;
                    endcase
                    if (pos == HDR_LAST) begin
                        if (outcome == ST_OK && an_left == 16'h0000)
                            outcome = ST_NO_ANS;
                        if (outcome != ST_OK)
                            settle(outcome);
                        else
                            phase = PH_NAME;
                    end else begin
                        pos = pos + 4'd1;
                    end
                end
                PH_NAME: begin
                    if (b == 8'h00)
                        name_done();
                    else if (b[7:6] == LBL_PTR)
                        phase = PH_PTR;
                    else if (b[7:6] != LBL_PLAIN)
                        settle(ST_BAD_LABEL);
                    else begin
                        skip_left = {8'h00, b};
                        phase     = PH_LABEL;
                    end
                end
                PH_LABEL: begin
                    skip_left = skip_left - 16'd1;
                    if (skip_left == 16'h0000)
                        phase = PH_NAME;
                end
                PH_PTR: name_done();
                PH_QFIX: begin
                    skip_left = skip_left - 16'd1;
                    if (skip_left == 16'h0000) begin
                        qd_left = qd_left - 16'd1;
                        phase   = PH_NAME;
                    end
                end
                PH_AFIX: begin
                    case (pos)
                        AF_TYPE_HI: rr_type[15:8] = b;
                        AF_TYPE_LO: rr_type[7:0] = b;
                        AF_LEN_HI:  rr_len[15:8] = b;
                        AF_LEN_LO:  rr_len[7:0] = b;
                        default: ;
                    endcase
                    if (pos == AF_LEN_LO) begin
                        pos = 4'd0;
                        if (rr_type == TYPE_A && rr_len == ADDR_LEN) begin
                            skip_left = ADDR_LEN;
                            addr_acc  = 32'h0;
                            phase     = PH_ADATA;
                        end else if (rr_len != 16'h0000) begin
                            skip_left = rr_len;
                            phase     = PH_ASKIP;
                        end else begin
                            answer_done();
                        end
                    end else begin
                        pos = pos + 4'd1;
                    end
                end
                PH_ADATA: begin
                    addr_acc  = {addr_acc[23:0], b};
                    skip_left = skip_left - 16'd1;
                    if (skip_left == 16'h0000)
                        settle(ST_OK);
                end
                PH_ASKIP: begin
                    skip_left = skip_left - 16'd1;
                    if (skip_left == 16'h0000)
                        answer_done();
                end
                default: ;
            endcase
        endfunction

        function void accept_byte(input logic [7:0] b, input logic last);
            t_result  r;
            logic [2:0] code;
            if (!settled)
                parse_byte(b);
            if (last) begin
                if (settled)
                    code = outcome;
                else if (phase == PH_HEADER)
                    code = ST_SHORT;
                else
                    code = ST_TRUNC;
                r.found   = (code == ST_OK);
                r.address = (code == ST_OK) ? addr_acc : 32'h0;
                r.status  = code;
                pending = {pending, r};
                clear();
            end
        endfunction

        function void flag_error(input string msg);
            errors++;
            if (errors <= 10)
                $display("%0t mismatch: %s", $time, msg);
        endfunction

        function void check_reply(input logic found, input logic [31:0] address,
                                  input logic [2:0] status);
            t_result want;
            if (pending.size() == 0) begin
                flag_error($sformatf("unexpected word found=%0b address=%h status=%0d",
                                     found, address, status));
                return;
            end
            want = pending.pop_front();
            if (found !== want.found)
                flag_error($sformatf("found exp %0b got %0b", want.found, found));
            if (address !== want.address)
                flag_error($sformatf("address exp %h got %h", want.address, address));
            if (status !== want.status)
                flag_error($sformatf("status exp %0d got %0d", want.status, status));
        endfunction

        function int unsigned close_out();
            if (pending.size() != 0)
                flag_error($sformatf("%0d result words never arrived", pending.size()));
            return errors;
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [15:0] i_cfg_data;
    logic        i_valid;
    logic        o_ready;
    logic [7:0]  i_data_byte;
    logic        i_last;
    logic        o_valid;
    logic        i_ready;
    logic        o_found;
    logic [31:0] o_address;
    logic [2:0]  o_status;

    dns_reply_tracker replies = new();
    logic [7:0]       pkt[$];
    int unsigned      sent_words = 0;

    dns_a_record_extractor i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_data_byte (i_data_byte),
        .i_last      (i_last),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_found     (o_found),
        .o_address   (o_address),
        .o_status    (o_status)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && o_ready)
            replies.accept_byte(i_data_byte, i_last);
        if (i_rst_n && o_valid && i_ready)
            replies.check_reply(o_found, o_address, o_status);
    end

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [15:0] rand_half();
        return 16'($urandom_range(0, 16'hFFFF));
    endfunction

    // mostly back to back, some short gaps, now and then a long one
    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic void put8(input logic [7:0] v);
        pkt = {pkt, v};
    endfunction

    function automatic void put16(input logic [15:0] v);
        put8(v[15:8]);
        put8(v[7:0]);
    endfunction

    // starts a new packet with a 12-byte header
    function automatic void put_header(input logic [15:0] id, input logic [7:0] flags_lo,
                                       input logic [15:0] qd, input logic [15:0] an);
        pkt.delete();
        put16(id);
        put8(rand_byte());
        put8(flags_lo);
        put16(qd);
        put16(an);
        put16(rand_half());
        put16(rand_half());
    endfunction

    function automatic void put_name();
        int unsigned n;
        int unsigned r;
        logic [7:0]  len;
        n = $urandom_range(0, 3);
        repeat (n) begin
            len = ($urandom_range(0, 99) < 5) ? 8'd63 : 8'($urandom_range(1, 6));
            put8(len);
            repeat (len) put8(rand_byte());
        end
        r = $urandom_range(0, 99);
        if (r < 4)
            put8(8'($urandom_range(8'h40, 8'hBF)));
        else if (r < 45) begin
            put8(8'($urandom_range(8'hC0, 8'hFF)));
            put8(rand_byte());
        end else
            put8(8'h00);
    endfunction

    function automatic void cut_to(input int unsigned n);
        while (pkt.size() > n)
            void'(pkt.pop_back());
    endfunction

    function automatic void build_reply(input logic [15:0] id);
        int unsigned r;
        logic [15:0] qd;
        logic [15:0] an;
        logic [15:0] rtype;
        logic [15:0] rdlen;
        logic [7:0]  flags_lo;
        qd = 16'($urandom_range(0, 2));
        an = ($urandom_range(0, 99) < 6) ? 16'd0 : 16'($urandom_range(1, 3));
        flags_lo = ($urandom_range(0, 99) < 88) ? {rand_byte() & 8'hF0} : rand_byte();
        r = $urandom_range(0, 99);
        put_header((r < 88) ? id : rand_half(), flags_lo,
                   (r >= 95) ? rand_half() : qd, (r >= 97) ? rand_half() : an);
        repeat (qd) begin
            put_name();
            put16(rand_half());
            put16(rand_half());
        end
        repeat (an) begin
            put_name();
            r = $urandom_range(0, 99);
            if (r < 55)      rtype = TYPE_A;
            else if (r < 70) rtype = 16'd5;
            else if (r < 85) rtype = 16'd28;
            else             rtype = rand_half();
            put16(rtype);
            put16(rand_half());
            put16(rand_half());
            put16(rand_half());
            r = $urandom_range(0, 99);
            if (rtype == TYPE_A && r < 80) rdlen = ADDR_LEN;
            else if (r < 90)               rdlen = 16'($urandom_range(1, 20));
            else                           rdlen = 16'd0;
            put16(rdlen);
            repeat (rdlen) put8(rand_byte());
        end
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 6)) put8(rand_byte());
        if ($urandom_range(0, 99) < 15)
            cut_to($urandom_range(1, pkt.size()));
    endfunction

    function automatic void build_noise();
        pkt.delete();
        repeat ($urandom_range(1, 40)) put8(rand_byte());
    endfunction

    task automatic send_word(input logic [7:0] b, input logic last, input int unsigned gap);
        if (gap != 0) begin
            @(negedge i_clk);
            i_valid     <= 1'b0;
            i_data_byte <= rand_byte();
            i_last      <= 1'($urandom_range(0, 1));
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_valid     <= 1'b1;
        i_data_byte <= b;
        i_last      <= last;
        do @(posedge i_clk); while (!o_ready);
        sent_words++;
    endtask

    task automatic send_packet(input bit no_gaps);
        foreach (pkt[i])
            send_word(pkt[i], i == pkt.size() - 1, no_gaps ? 0 : idle_len());
    endtask

    // stops sending and waits until every result word still owed has been checked
    task automatic wait_idle();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (replies.pending.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_id(input logic [15:0] v);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        replies.id_cfg = v;
    endtask

    task automatic run_directed(input logic [15:0] id);
        // packet ends in the header
        pkt = {8'h00};
        send_packet(1'b0);
        // every header fault at once, id reported, trailing byte ignored
        put_header(~id, 8'h0F, 16'd0, 16'd0);
        put8(8'hAB);
        send_packet(1'b1);
        put_header(id, 8'h03, 16'd0, 16'd0);
        send_packet(1'b0);
        put_header(id, 8'h00, 16'd0, 16'd0);
        send_packet(1'b1);
        // reserved label type 10
        put_header(id, 8'h00, 16'd0, 16'd1);
        put8(8'h80);
        send_packet(1'b0);
        // question by pointer, answer by label, all-ones address, byte after it ignored
        put_header(id, 8'h00, 16'd1, 16'd1);
        put16(16'hC00C);
        put16(16'h0001);
        put16(16'h0001);
        put8(8'h01);
        put8(8'hFF);
        put8(8'h00);
        put16(TYPE_A);
        put16(16'h0001);
        put16(16'hFFFF);
        put16(16'hFFFF);
        put16(ADDR_LEN);
        put16(16'hFFFF);
        put16(16'hFFFF);
        put8(8'h55);
        send_packet(1'b1);
        // ends inside a pointer
        put_header(id, 8'h00, 16'd0, 16'd1);
        put8(8'hC0);
        send_packet(1'b0);
        // only answer is not an A record, more bytes follow
        put_header(id, 8'h00, 16'd0, 16'd1);
        put16(16'hC00C);
        put16(16'h0005);
        put16(16'h0001);
        put16(16'h0000);
        put16(16'h0000);
        put16(16'h0000);
        put8(8'h99);
        send_packet(1'b0);
    endtask

    initial begin
        #4000000;
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        int unsigned n;
        forever begin
            n = idle_len();
            if (n != 0) begin
                @(negedge i_clk);
                i_ready <= 1'b0;
                repeat (n - 1) @(negedge i_clk);
            end
            @(negedge i_clk);
            i_ready <= 1'b1;
            if ($urandom_range(0, 19) == 0)
                repeat ($urandom_range(50, 200)) @(negedge i_clk);
            else
                repeat ($urandom_range(0, 6)) @(negedge i_clk);
        end
    end

    initial begin
        logic [15:0] ids[5];
        int unsigned target;
        int unsigned pick;
        i_clk       = 1'b0;
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_data  = 16'h0000;
        i_valid     = 1'b0;
        i_data_byte = 8'h00;
        i_last      = 1'b0;
        i_ready     = 1'b0;
        ids[0] = 16'hC35A;
        ids[1] = 16'hFFFF;
        ids[2] = 16'h0000;
        ids[3] = rand_half();
        ids[4] = rand_half();
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (ids[k]) begin
            write_id(ids[k]);
            if (k == 0)
                run_directed(ids[k]);
            target = sent_words + 300;
            while (sent_words < target) begin
                if ($urandom_range(0, 99) < 5)
                    wait_idle();
                pick = $urandom_range(0, 99);
                if (pick < 75)
                    build_reply(replies.id_cfg);
                else if (pick < 88) begin
                    put_header(replies.id_cfg, 8'h00, rand_half(), rand_half());
                    cut_to($urandom_range(1, 11));
                end else
                    build_noise();
                send_packet($urandom_range(0, 9) < 3);
            end
            wait_idle();
        end

        repeat (8) @(posedge i_clk);
        if (replies.close_out() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
